FILE: src/gti_pkg.sv
// Shared types and constants for the gyro turn angle integrator.
// Holds the action codes, sequencer states, control structs and the
// fixed-point reciprocal of the angle scale factor. No dependencies.
`default_nettype none

package gti_pkg;

   // Default number of calibration beats averaged into the offset
   localparam int CAL_SAMPLES_DEF = 1024;

   // Angle increment is rate * dt * ANGLE_SCALE / ANGLE_DIV
   localparam int ANGLE_SCALE = 14680064;
   localparam int ANGLE_DIV   = 17578125;

   // Degrees per full turn, and the bias of the offset-binary heading top
   localparam int DEG_PER_TURN = 360;
   localparam int DEG_HALF     = DEG_PER_TURN / 2;
   localparam int DEG_W        = 9;

   // Field widths
   localparam int DATA_W = 16;
   localparam int HEAD_W = 32;
   localparam int SUM_W  = 27;

   // Shared multiplier: A operand by one half of a split reciprocal
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 28;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int RECIP_W = 2 * MUL_B_W;
   localparam int ACC_W   = RECIP_W + MUL_A_W;

   // Reciprocal shifts: angle path and calibration mean
   localparam int ANGLE_SHIFT = 56;
   localparam int CAL_SHIFT   = 43;

   // Rounded-up reciprocal of the angle scale, exact for all 31-bit products
   localparam logic [ACC_W-1:0] ANGLE_NUM = ACC_W'(ANGLE_SCALE) << ANGLE_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_ANGLE =
      RECIP_W'((ANGLE_NUM + ACC_W'(ANGLE_DIV) - ACC_W'(1)) / ACC_W'(ANGLE_DIV));

   typedef enum logic [1:0] {
      ACT_CALIB  = 2'd0,
      ACT_RESET  = 2'd1,
      ACT_UPDATE = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_D,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_APPLY,
      ST_DEG,
      ST_DONE
   } state_type;

   // One strobe per sequencer step
   typedef struct packed {
      logic take;
      logic prep;
      logic mul_d;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic apply;
      logic deg;
      logic done;
   } ctl_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic is_update;
      logic cal_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: src/gyro_turn_angle_integrator_unit.sv
// Flow: each taken beat goes through prepare, degrees and done; an update beat adds
// the dt multiply first, and an update or final calibration beat adds both reciprocal
// passes, accumulate and apply before degrees. rsp_valid rises as the block returns
// to idle, and req_ready returns in that same cycle; an untaken result stalls done.
// Reset: synchronous, active high; clears heading, offset, calibration and result
// state at once, with no clearing pass.
`default_nettype none

module gyro_turn_angle_integrator_unit #(
   parameter int CAL_SAMPLES = gti_pkg::CAL_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic signed [gti_pkg::DATA_W-1:0] req_gyro_z,
   input  logic [gti_pkg::DATA_W-1:0]        req_time_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [gti_pkg::DEG_W-1:0]  rsp_angle_deg,
   output logic [gti_pkg::HEAD_W-1:0]        rsp_angle_raw,
   output logic signed [gti_pkg::DATA_W-1:0] rsp_turn_rate,
   output logic                              rsp_calibrated
);
   import gti_pkg::*;

   localparam int CntW = $clog2(CAL_SAMPLES + 1);
   // Rounded-up reciprocal for the calibration mean
   localparam logic [RECIP_W-1:0] RecipCal =
      RECIP_W'(((ACC_W'(1) << CAL_SHIFT) + ACC_W'(CAL_SAMPLES) - ACC_W'(1))
               / ACC_W'(CAL_SAMPLES));

   ctl_type  ctl;
   stat_type stat;

   // Captured beat
   logic [1:0]        action_ff;
   logic [DATA_W-1:0] gyro_ff;
   logic [DATA_W-1:0] time_ff;

   // Tracker state
   logic [DATA_W-1:0] offset_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CntW-1:0]   count_ff;
   logic [DATA_W-1:0] last_time_ff;
   logic [HEAD_W-1:0] heading_ff;
   logic [DATA_W-1:0] last_rate_ff;
   logic              ready_ff;

   // Working registers
   logic               neg_ff;
   logic [MUL_A_W-1:0] mag_ff;
   logic [ACC_W-1:0]   acc_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [DEG_W-1:0]  deg_ff;
   logic [HEAD_W-1:0] raw_ff;
   logic [DATA_W-1:0] rate_ff;
   logic              cal_ff;

   // Combinational datapath
   logic               is_update;
   logic               is_calib;
   logic               is_reset;
   logic [DATA_W-1:0]  rate_w;
   logic [DATA_W-1:0]  rate_mag;
   logic [DATA_W-1:0]  dt_w;
   logic [SUM_W-1:0]   sum_w;
   logic [SUM_W-1:0]   sum_mag;
   logic [CntW-1:0]    cnt_inc;
   logic               cal_last;
   logic [RECIP_W-1:0] recip_sel;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [MUL_P_W-1:0] prod;
   logic [HEAD_W-1:0]  quot;
   logic [HEAD_W-1:0]  quot_s;
   logic [DEG_W:0]     deg_w;

   gti_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctl       (ctl)
   );

   gti_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Decode the beat and form rate, dt and the calibration sum
   assign is_update = (action_ff == ACT_UPDATE);
   assign is_calib  = (action_ff == ACT_CALIB);
   assign is_reset  = (action_ff == ACT_RESET);
   assign rate_w    = gyro_ff - offset_ff;
   assign rate_mag  = rate_w[DATA_W-1] ? (~rate_w + DATA_W'(1)) : rate_w;
   assign dt_w      = time_ff - last_time_ff;
   assign sum_w     = sum_ff + {{(SUM_W-DATA_W){gyro_ff[DATA_W-1]}}, gyro_ff};
   assign sum_mag   = sum_w[SUM_W-1] ? (~sum_w + SUM_W'(1)) : sum_w;
   assign cnt_inc   = count_ff + CntW'(1);
   assign cal_last  = is_calib && (cnt_inc == CntW'(CAL_SAMPLES));
   assign recip_sel = is_update ? RECIP_ANGLE : RecipCal;

   assign stat.is_update = is_update;
   assign stat.cal_last  = cal_last;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Steer the shared multiplier for the current step
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (ctl.mul_d) begin
         op_a = MUL_A_W'(rate_mag);
         op_b = MUL_B_W'(dt_w);
      end else if (ctl.mul_lo) begin
         op_a = is_update ? prod[MUL_A_W-1:0] : mag_ff;
         op_b = recip_sel[MUL_B_W-1:0];
      end else if (ctl.mul_hi) begin
         op_a = mag_ff;
         op_b = recip_sel[RECIP_W-1:MUL_B_W];
      end else begin
         // Degree scaling otherwise, so the product holds while the result waits
         op_a = MUL_A_W'({~heading_ff[HEAD_W-1], heading_ff[HEAD_W-2:HEAD_W-DATA_W]});
         op_b = MUL_B_W'(DEG_PER_TURN);
      end
   end

   // Pick the truncated quotient and restore its sign
   assign quot   = is_update ? acc_ff[ANGLE_SHIFT +: HEAD_W] : acc_ff[CAL_SHIFT +: HEAD_W];
   assign quot_s = neg_ff ? (~quot + HEAD_W'(1)) : quot;

   // Remove the offset-binary bias from the scaled heading
   assign deg_w = (DEG_W + 1)'(prod[DATA_W +: DEG_W]) - (DEG_W + 1)'(DEG_HALF);

   // Capture the beat on acceptance
   always_ff @(posedge clock) begin
      if (req_valid && ctl.take) begin
         action_ff <= req_action;
         gyro_ff   <= req_gyro_z;
         time_ff   <= req_time_us;
      end
   end

   // Working registers for the multiply chain
   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         if (is_update) begin
            neg_ff <= rate_w[DATA_W-1];
         end else begin
            neg_ff <= sum_w[SUM_W-1];
            mag_ff <= MUL_A_W'(sum_mag);
         end
      end
      if (ctl.mul_lo) begin
         mag_ff <= op_a;
      end
      if (ctl.mul_hi) begin
         acc_ff <= ACC_W'(prod);
      end else if (ctl.acc) begin
         acc_ff <= acc_ff + (ACC_W'(prod) << MUL_B_W);
      end
   end

   // Tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         last_time_ff <= '0;
         heading_ff   <= '0;
         last_rate_ff <= '0;
         ready_ff     <= 1'b0;
      end else begin
         if (ctl.prep) begin
            if (is_calib) begin
               sum_ff   <= cal_last ? '0 : sum_w;
               count_ff <= cal_last ? '0 : cnt_inc;
            end
            if (is_reset) begin
               last_time_ff <= time_ff;
               heading_ff   <= '0;
            end
            if (is_update) begin
               last_rate_ff <= rate_w;
            end
         end
         // Advance the timestamp only once dt has been through the multiplier
         if (ctl.apply) begin
            if (is_update) begin
               heading_ff   <= heading_ff + quot_s;
               last_time_ff <= time_ff;
            end else begin
               offset_ff <= quot_s[DATA_W-1:0];
               ready_ff  <= 1'b1;
            end
         end
      end
   end

   // Result register: load on the last step, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.done) begin
         deg_ff  <= deg_w[DEG_W-1:0];
         raw_ff  <= heading_ff;
         rate_ff <= last_rate_ff;
         cal_ff  <= ready_ff;
      end
   end

   assign req_ready      = ctl.take;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_angle_deg  = $signed(deg_ff);
   assign rsp_angle_raw  = raw_ff;
   assign rsp_turn_rate  = $signed(rate_ff);
   assign rsp_calibrated = cal_ff;

   // Once calibrated, the block stays calibrated
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("calibrated flag fell");

   // The sample count never reaches the calibration length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CntW'(CAL_SAMPLES))
      else $error("calibration count out of range");

   // A taken beat makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after a beat was taken");

   // A result appears only from the last step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.done))
      else $error("result raised outside the final step");

   // At most one step strobe at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctl))
      else $error("several sequencer steps active");

endmodule

`default_nettype wire

FILE: src/gti_mul.sv
// Shared unsigned multiplier with a registered product.
// Used for rate * dt, both reciprocal halves and the degree scaling.
// Depends on gti_pkg.
`default_nettype none

module gti_mul (
   input  logic                        clock,
   input  logic [gti_pkg::MUL_A_W-1:0] op_a,
   input  logic [gti_pkg::MUL_B_W-1:0] op_b,
   output logic [gti_pkg::MUL_P_W-1:0] prod
);
   import gti_pkg::*;

   logic [MUL_P_W-1:0] prod_in;
   logic [MUL_P_W-1:0] prod_ff;

   // Form the full-width product
   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   // Register the product for the next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: src/gti_seq.sv
// Step sequencer for the gyro turn angle integrator. Depends on gti_pkg.
// Walks one beat through prepare, multiplier passes, apply and degrees;
// the passes and apply are for updates and final calibration beats only.
`default_nettype none

module gti_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  gti_pkg::stat_type stat,
   output gti_pkg::ctl_type  ctl
);
   import gti_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the current step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through the steps and raise the matching strobe
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.take = 1'b1;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
            if (stat.is_update) begin
               state_in = ST_MUL_D;
            end else if (stat.cal_last) begin
               state_in = ST_MUL_LO;
            end else begin
               state_in = ST_DEG;
            end
         end
         ST_MUL_D: begin
            ctl.mul_d = 1'b1;
            state_in  = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            ctl.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            ctl.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            ctl.acc  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = ST_DEG;
         end
         ST_DEG: begin
            ctl.deg  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               ctl.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: tb/gyro_turn_angle_integrator_unit_test.sv
// Self-checking bench for gyro_turn_angle_integrator_unit: heading predictor,
// result scoreboard, randomised beats with idling on both channels.
// Depends on gti_pkg and the unit under test only.

module gyro_turn_angle_integrator_unit_test;
   import gti_pkg::*;

   // Spare action code: the unit must ignore it and report its state
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int CAL_N = CAL_SAMPLES_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int LONG_HOLD_AT = 1500;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic signed [DEG_W-1:0]  deg;
      logic [HEAD_W-1:0]        raw;
      logic signed [DATA_W-1:0] rate;
      logic                     cal;
   } heading_result_type;

   // Heading predictor and queue of predicted results
   class heading_scoreboard;
      logic [DATA_W-1:0] offset;
      logic [SUM_W-1:0]  cal_sum;
      int unsigned       cal_count;
      logic [DATA_W-1:0] last_t;
      logic [HEAD_W-1:0] heading;
      logic [DATA_W-1:0] rate;
      bit                ready;
      heading_result_type expected_q[$];
      int unsigned       errors;

      function new();
         offset = '0;
         cal_sum = '0;
         cal_count = 0;
         last_t = '0;
         heading = '0;
         rate = '0;
         ready = 1'b0;
         errors = 0;
      endfunction

      // Advance the heading state by one accepted request beat
      function void note_request(logic [1:0] act, logic [DATA_W-1:0] gz,
                                 logic [DATA_W-1:0] t);
         longint sum_s;
         longint prod;
         longint incr;
         logic signed [DATA_W-1:0] rate_n;
         logic [DATA_W-1:0] dt;
         logic signed [DATA_W-1:0] top;
         int scaled;
         heading_result_type e;
         case (act)
            ACT_CALIB: begin
               cal_sum = cal_sum + {{(SUM_W-DATA_W){gz[DATA_W-1]}}, gz};
               cal_count++;
               // Mean of the run, truncated toward zero, then restart the run
               if (cal_count >= CAL_N) begin
                  sum_s = $signed(cal_sum);
                  offset = DATA_W'(sum_s / CAL_N);
                  ready = 1'b1;
                  cal_sum = '0;
                  cal_count = 0;
               end
            end
            ACT_RESET: begin
               last_t = t;
               heading = '0;
            end
            ACT_UPDATE: begin
               rate_n = $signed(gz) - $signed(offset);
               dt = t - last_t;
               prod = longint'(rate_n) * longint'(dt);
               incr = prod * longint'(ANGLE_SCALE) / longint'(ANGLE_DIV);
               rate = rate_n;
               last_t = t;
               heading = heading + HEAD_W'(incr);
            end
            default: ;
         endcase
         // Degrees: floor of the signed top half times 360 over 2^16
         top = heading[HEAD_W-1 -: DATA_W];
         scaled = int'(top) * DEG_PER_TURN;
         e.deg = DEG_W'(scaled >>> DATA_W);
         e.raw = heading;
         e.rate = rate;
         e.cal = ready;
         expected_q.push_back(e);
      endfunction

      // Compare one response beat with the oldest prediction
      function void check_result(heading_result_type got);
         heading_result_type e;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing predicted: angle_raw %h", got.raw);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.deg !== e.deg) begin
            $error("angle_deg: expected %0d, got %0d", e.deg, got.deg);
            errors++;
         end
         if (got.raw !== e.raw) begin
            $error("angle_raw: expected %h, got %h", e.raw, got.raw);
            errors++;
         end
         if (got.rate !== e.rate) begin
            $error("turn_rate: expected %0d, got %0d", e.rate, got.rate);
            errors++;
         end
         if (got.cal !== e.cal) begin
            $error("calibrated: expected %0b, got %0b", e.cal, got.cal);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_action;
   logic signed [DATA_W-1:0] req_gyro_z;
   logic [DATA_W-1:0]        req_time_us;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DEG_W-1:0]  rsp_angle_deg;
   logic [HEAD_W-1:0]        rsp_angle_raw;
   logic signed [DATA_W-1:0] rsp_turn_rate;
   logic                     rsp_calibrated;

   heading_scoreboard sb;
   int send_burst = 0;
   int rsp_hold = 0;
   int rsp_steady = 0;
   int unsigned rsp_beats = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;

   gyro_turn_angle_integrator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_gyro_z     (req_gyro_z),
      .req_time_us    (req_time_us),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_angle_deg  (rsp_angle_deg),
      .rsp_angle_raw  (rsp_angle_raw),
      .rsp_turn_rate  (rsp_turn_rate),
      .rsp_calibrated (rsp_calibrated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sender idle length: mostly none or short, a few long, bursts with none
   function automatic int sender_gap();
      int r;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Random reading spread around a centre, wrapped to 16 bits
   function automatic logic [DATA_W-1:0] around(int centre, int spread);
      return DATA_W'(centre + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Offer one request beat and hold it until taken
   task automatic send_beat(input logic [1:0] act, input logic [DATA_W-1:0] gz,
                            input logic [DATA_W-1:0] t);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_gyro_z <= gz;
      req_time_us <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(act, gz, t);
   endtask

   // Receiver: check each response beat, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result({rsp_angle_deg, rsp_angle_raw, rsp_turn_rate, rsp_calibrated});
            rsp_beats++;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && rsp_beats >= LONG_HOLD_AT) begin
            // Hold off long enough for the unit to fill and stall its input
            long_hold_done = 1'b1;
            rsp_hold = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (rsp_steady > 0) begin
            rsp_steady--;
            rsp_ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:59]:  rsp_ready <= 1'b1;
               [60:62]: begin
                  rsp_steady = $urandom_range(30, 80);
                  rsp_ready <= 1'b1;
               end
               [63:96]: begin
                  rsp_hold = $urandom_range(0, 3);
                  rsp_ready <= 1'b0;
               end
               default: begin
                  rsp_hold = $urandom_range(15, 60);
                  rsp_ready <= 1'b0;
               end
            endcase
         end
      end
   end

   // Watchdog: stop when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("gyro_turn_angle_integrator_unit_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int bias;
      int unsigned sel;
      logic [DATA_W-1:0] t_now;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_CALIB;
      req_gyro_z <= '0;
      req_time_us <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: updates before calibration, full-scale rates and intervals
      send_beat(ACT_UPDATE, 16'h7FFF, 16'hFFFF);
      send_beat(ACT_UPDATE, 16'h8000, 16'hFFFE);
      send_beat(ACT_SPARE, 16'h1234, 16'h5678);
      send_beat(ACT_RESET, 16'h0000, 16'h0000);
      send_beat(ACT_UPDATE, 16'h0000, 16'h0000);
      send_beat(ACT_UPDATE, 16'hFFFF, 16'h0001);
      // Calibration beats at the extremes leave the heading alone
      send_beat(ACT_CALIB, 16'h8000, 16'hFFFF);
      send_beat(ACT_CALIB, 16'h7FFF, 16'h0000);
      send_beat(ACT_CALIB, 16'h0000, 16'hAAAA);
      send_beat(ACT_RESET, 16'h8000, 16'hFFFF);
      send_beat(ACT_UPDATE, 16'd1000, 16'h0000);
      send_beat(ACT_UPDATE, 16'h8000, 16'hFFFF);
      send_beat(ACT_UPDATE, 16'h7FFF, 16'hFFFE);
      send_beat(ACT_UPDATE, 16'h7FFF, 16'hFFFD);
      send_beat(ACT_SPARE, 16'hFFFF, 16'hFFFF);
      send_beat(ACT_RESET, 16'h7FFF, 16'h5555);
      send_beat(ACT_UPDATE, 16'h8001, 16'h5554);

      // Noise: any action, any reading, any timestamp
      repeat (250) begin
         send_beat(2'($urandom_range(0, 3)), DATA_W'($urandom), DATA_W'($urandom));
      end

      // Calibration run around a steady bias, a few updates and resets mixed in
      bias = int'($urandom_range(0, 600)) - 300;
      t_now = DATA_W'($urandom);
      while (!sb.ready) begin
         r = $urandom_range(0, 99);
         if (r < 90) begin
            send_beat(ACT_CALIB, around(bias, 60), DATA_W'($urandom));
         end else if (r < 96) begin
            t_now = t_now + DATA_W'($urandom_range(1000, 1500));
            send_beat(ACT_UPDATE, around(bias, 2000), t_now);
         end else begin
            send_beat(ACT_RESET, DATA_W'($urandom), t_now);
         end
      end

      // Heading tracking at roughly the sample rate, with odd intervals and noise
      repeat (500) begin
         r = $urandom_range(0, 99);
         sel = $urandom_range(0, 9);
         if (sel < 7) t_now = t_now + DATA_W'(1210 + $urandom_range(0, 80));
         else if (sel < 9) t_now = t_now + DATA_W'($urandom_range(0, 8000));
         else t_now = DATA_W'($urandom);
         if (r < 78) begin
            if ($urandom_range(0, 9) < 7) send_beat(ACT_UPDATE, around(bias, 3000), t_now);
            else send_beat(ACT_UPDATE, DATA_W'($urandom), t_now);
         end else if (r < 86) begin
            send_beat(ACT_RESET, DATA_W'($urandom), t_now);
         end else if (r < 93) begin
            send_beat(ACT_CALIB, around(bias, 60), DATA_W'($urandom));
         end else begin
            send_beat(2'($urandom_range(0, 3)), DATA_W'($urandom), DATA_W'($urandom));
         end
      end

      // Drain: wait for every predicted beat, then watch for strays
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("gyro_turn_angle_integrator_unit_test: done, clean");
      end else begin
         $display("gyro_turn_angle_integrator_unit_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: gyro_turn_angle_integrator_unit.f
src/gti_pkg.sv
src/gti_mul.sv
src/gti_seq.sv
src/gyro_turn_angle_integrator_unit.sv
tb/gyro_turn_angle_integrator_unit_test.sv
